[rtl/core/depth_texture_sort_batcher_defines.svh]
// Assertion macros for the sprite sort batcher checker
`ifndef DEPTH_TEXTURE_SORT_BATCHER_DEFINES_SVH
`define DEPTH_TEXTURE_SORT_BATCHER_DEFINES_SVH
`define DTSB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DTSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/core/dtsb_pkg.sv]
// Package: types and constants of the sprite sort batcher
package dtsb_pkg;
	localparam int unsigned IDX_PER_SPRITE = 6;
	typedef enum logic [1:0] {OP_BEGIN = 2'd0, OP_DRAW = 2'd1, OP_END = 2'd2} op_t;
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] tex;
		logic signed [15:0] depth;
	} rec_t;
	typedef struct packed {
		logic        kind;
		logic [15:0] out_tag;
		logic [15:0] out_texture;
		logic [7:0]  index_offset;
		logic [7:0]  index_count;
		logic        last;
	} res_t;
	typedef enum logic [2:0] {
		ST_IDLE, ST_DECIDE, ST_EMIT_REC, ST_EMIT_RUN, ST_STORE
	} state_t;
	typedef struct packed {
		logic clear;
		logic store;
		logic start_rec;
		logic start_run;
		logic step;
	} cmd_t;
	typedef struct packed {
		logic rec_done;
		logic run_done;
		logic empty;
		logic full;
	} sts_t;
endpackage

[rtl/core/dtsb_if.sv]
// Valid/ready channel interfaces of the sprite sort batcher
interface dtsb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] sprite_tag;
	logic [15:0] texture_id;
	logic signed [15:0] depth_key;
	modport source (output valid, op, sprite_tag, texture_id, depth_key, input ready);
	modport sink (input valid, op, sprite_tag, texture_id, depth_key, output ready);
endinterface

interface dtsb_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] out_tag;
	logic [15:0] out_texture;
	logic [7:0]  index_offset;
	logic [7:0]  index_count;
	logic        last;
	modport source (output valid, kind, out_tag, out_texture, index_offset, index_count,
		last, input ready);
	modport sink (input valid, kind, out_tag, out_texture, index_offset, index_count,
		last, output ready);
endinterface

interface dtsb_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/core/dtsb_datapath.sv]
// Datapath: sorted insertion chain of cells and emission counters
module dtsb_datapath #(
	parameter int MAX_SPRITES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dtsb_pkg::cmd_t    cmd,
	input  dtsb_pkg::rec_t    new_rec,
	input  logic [5:0]        limit,
	output dtsb_pkg::sts_t    sts,
	output dtsb_pkg::res_t    res,
	output logic              run_end
);
	import dtsb_pkg::*;
	localparam int CW = $clog2(MAX_SPRITES + 1);
	localparam int IW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;

	rec_t cell_q [MAX_SPRITES];
	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] run_start_q;
	logic [MAX_SPRITES-1:0] after;
	logic [CW-1:0] eff_lim;

	always_comb begin
		if (limit == 6'd0) eff_lim = CW'(1);
		else if (32'(limit) > MAX_SPRITES) eff_lim = CW'(MAX_SPRITES);
		else eff_lim = CW'(limit);
	end

	// new record goes after every held record that is not strictly after it
	always_comb begin
		for (int i = 0; i < MAX_SPRITES; i++) begin
			after[i] = (i < 32'(count_q)) &&
				((new_rec.depth < cell_q[i].depth) ||
				 ((new_rec.depth == cell_q[i].depth) && (new_rec.tex < cell_q[i].tex)));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			for (int i = 0; i < MAX_SPRITES; i++) begin
				if (after[i]) begin
					if (i + 1 < MAX_SPRITES) cell_q[i+1] <= cell_q[i];
				end
				if (i == 0) begin
					if (after[0]) cell_q[0] <= new_rec;
				end else if (after[i] && !after[i-1]) begin
					cell_q[i] <= new_rec;
				end
			end
			if (count_q < CW'(MAX_SPRITES) && !after[IW'(count_q - CW'(1))] && count_q != '0)
				cell_q[IW'(count_q)] <= new_rec;
			if (count_q == '0) cell_q[0] <= new_rec;
		end
	end

	logic [CW-1:0] pos_n;
	logic same_next;
	always_comb begin
		pos_n = pos_q + CW'(1);
		same_next = (pos_n < count_q) && (cell_q[IW'(pos_n)].tex == cell_q[IW'(pos_q)].tex);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q <= '0;
			run_start_q <= '0;
		end else begin
			if (cmd.clear) count_q <= '0;
			else if (cmd.store && count_q < CW'(MAX_SPRITES)) count_q <= count_q + CW'(1);
			if (cmd.start_rec || cmd.start_run) begin
				pos_q <= '0;
				run_start_q <= '0;
			end else if (cmd.step) begin
				pos_q <= pos_n;
				if (sts.run_done == 1'b0 && !same_next && res.kind) run_start_q <= pos_n;
			end
		end
	end

	assign run_end = !same_next;

	always_comb begin
		sts.empty = (count_q == '0);
		sts.full = (count_q >= eff_lim);
		sts.rec_done = (pos_n >= count_q);
		sts.run_done = (pos_n >= count_q);
	end

	// record form during the first pass, run form during the second
	logic emitting_run_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emitting_run_q <= 1'b0;
		else if (cmd.start_run) emitting_run_q <= 1'b1;
		else if (cmd.start_rec || cmd.clear) emitting_run_q <= 1'b0;
	end

	logic [CW-1:0] run_len;
	assign run_len = pos_n - run_start_q;

	always_comb begin
		res = '0;
		res.kind = emitting_run_q;
		res.out_texture = cell_q[IW'(pos_q)].tex;
		if (!emitting_run_q) begin
			res.out_tag = cell_q[IW'(pos_q)].tag;
			res.last = 1'b0;
		end else begin
			res.out_texture = cell_q[IW'(run_start_q)].tex;
			res.index_offset = 8'(run_start_q * 8'(IDX_PER_SPRITE));
			res.index_count = 8'(run_len * 8'(IDX_PER_SPRITE));
			res.last = sts.run_done;
		end
	end
endmodule

[rtl/core/dtsb_ctrl.sv]
// Controller: batch state machine and output register
module dtsb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	dtsb_in_if.sink        in_ch,
	dtsb_out_if.source     out_ch,
	input  dtsb_pkg::sts_t sts,
	input  dtsb_pkg::res_t res,
	input  logic           run_end,
	output dtsb_pkg::cmd_t cmd,
	output dtsb_pkg::rec_t new_rec
);
	import dtsb_pkg::*;
	state_t state_q, state_n;
	logic active_q;
	logic [1:0] op_q;
	rec_t rec_q;
	logic ov_q;
	res_t ob_q;
	logic slot_free, show;

	assign slot_free = !ov_q || out_ch.ready;
	assign new_rec = rec_q;
	assign in_ch.ready = (state_q == ST_IDLE);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (in_ch.valid) state_n = ST_DECIDE;
			ST_DECIDE: begin
				if (op_q == OP_BEGIN) state_n = ST_IDLE;
				else if (op_q == OP_DRAW) begin
					if (!active_q) state_n = ST_IDLE;
					else if (sts.full && !sts.empty) state_n = ST_EMIT_REC;
					else state_n = ST_STORE;
				end else if (op_q == OP_END) begin
					if (!active_q || sts.empty) state_n = ST_IDLE;
					else state_n = ST_EMIT_REC;
				end else state_n = ST_IDLE;
			end
			ST_EMIT_REC: if (slot_free && sts.rec_done) state_n = ST_EMIT_RUN;
			ST_EMIT_RUN: if (slot_free && sts.run_done)
				state_n = (op_q == OP_DRAW) ? ST_STORE : ST_IDLE;
			ST_STORE: state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		show = 1'b0;
		case (state_q)
			ST_DECIDE: begin
				if (op_q == OP_BEGIN) cmd.clear = 1'b1;
				else if (op_q == OP_END && active_q && sts.empty) cmd.clear = 1'b1;
				if (state_n == ST_EMIT_REC) cmd.start_rec = 1'b1;
			end
			ST_EMIT_REC: if (slot_free) begin
				show = 1'b1;
				cmd.step = !sts.rec_done;
				cmd.start_run = sts.rec_done;
			end
			ST_EMIT_RUN: if (slot_free) begin
				show = run_end;
				cmd.step = 1'b1;
				cmd.clear = sts.run_done;
			end
			ST_STORE: cmd.store = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			rec_q.tag <= in_ch.sprite_tag;
			rec_q.tex <= in_ch.texture_id;
			rec_q.depth <= in_ch.depth_key;
		end
		if (show) ob_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= 1'b0;
			op_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (in_ch.valid && in_ch.ready) op_q <= in_ch.op;
			if (state_q == ST_DECIDE) begin
				if (op_q == OP_BEGIN) active_q <= 1'b1;
				else if (op_q == OP_END) active_q <= 1'b0;
			end
			if (show) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.kind = ob_q.kind;
	assign out_ch.out_tag = ob_q.out_tag;
	assign out_ch.out_texture = ob_q.out_texture;
	assign out_ch.index_offset = ob_q.index_offset;
	assign out_ch.index_count = ob_q.index_count;
	assign out_ch.last = ob_q.last;
endmodule

[rtl/core/depth_texture_sort_batcher.sv]
// Top level of the depth/texture sprite sort batcher
// Usage:
//   in_ch  : begin/draw/end words (op, sprite_tag, texture_id, depth_key).
//   cfg_ch : batch_limit write (6 bits), taken at any time, use while idle.
//   out_ch : sorted sprite records, then one draw command per texture run,
//            last marks the final word of an emission.
// Each draw is inserted in sorted place into a chain of MAX_SPRITES cells in
// the store state; a draw is accepted, then decided, then stored.
// An emission of n sprites and r runs walks the n records once in record form,
// then every cell again for the r run commands, waiting while out_ch stalls.
// Reset clears the batch and makes it inactive; limit returns to 32.
// When out_ch stalls the single output register holds and the walk waits.
module depth_texture_sort_batcher #(
	parameter int MAX_SPRITES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	dtsb_in_if.sink     in_ch,
	dtsb_out_if.source  out_ch,
	dtsb_cfg_if.sink    cfg_ch
);
	import dtsb_pkg::*;
	cmd_t cmd;
	sts_t sts;
	res_t res;
	rec_t new_rec;
	logic run_end;
	logic [5:0] limit_q;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= 6'd32;
		else if (cfg_ch.valid) limit_q <= cfg_ch.data;
	end

	dtsb_datapath #(.MAX_SPRITES(MAX_SPRITES)) u_dp (
		.clk, .arst_n, .cmd, .new_rec, .limit(limit_q), .sts, .res, .run_end
	);
	dtsb_ctrl u_ctrl (
		.clk, .arst_n, .in_ch, .out_ch, .sts, .res,
		.run_end, .cmd, .new_rec
	);
endmodule

[rtl/core/dtsb_checker.sv]
// Port checker for the sprite sort batcher, bound to the top level
`include "depth_texture_sort_batcher_defines.svh"
module dtsb_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic out_kind,
	input logic out_last,
	input logic [7:0] out_count
);
	`DTSB_ASSERT_IMPL(a_last_is_cmd, clk, arst_n, out_valid && out_last, out_kind)
	`DTSB_ASSERT_IMPL(a_cmd_count, clk, arst_n, out_valid && out_kind, out_count != 8'd0)
	`DTSB_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

bind depth_texture_sort_batcher dtsb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_kind(out_ch.kind), .out_last(out_ch.last), .out_count(out_ch.index_count)
);
